FILE: src/i2cm_pkg.sv
// Package for the I2C master bit engine.
// Holds the phase and command encodings, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam logic [3:0] RECOVERY_PULSES = 4'd9;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd11;
  localparam logic [7:0] ACK_WAIT_RESET    = 8'd250;
  localparam logic [3:0] RECOVERY_RESET    = 4'd5;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_ACK_WAIT    = 2'd1,
    CFG_RECOVERY    = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_NACK = 3'd4,
    CMD_STOP      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ACK  = 2'd1,
    ST_STUCK   = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    P_IDLE     = 5'd0,
    P_CHK      = 5'd1,
    P_REC_LO   = 5'd2,
    P_REC_HI   = 5'd3,
    P_ST_A     = 5'd4,
    P_ST_B     = 5'd5,
    P_ST_C     = 5'd6,
    P_WR_LO    = 5'd7,
    P_WR_HI    = 5'd8,
    P_WR_END   = 5'd9,
    P_ACK_SET  = 5'd10,
    P_ACK_POLL = 5'd11,
    P_RD_LO    = 5'd12,
    P_RD_HI    = 5'd13,
    P_RA_LO    = 5'd14,
    P_RA_HI    = 5'd15,
    P_RA_END   = 5'd16,
    P_SP_A     = 5'd17,
    P_SP_B     = 5'd18,
    P_SP_C     = 5'd19
  } phase_e;

endpackage

FILE: src/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: bus sequencer and result register.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

// Each input item is one timing tick and yields exactly one result item. The
// engine takes one tick per clock unless stalled: the sequencer state advances
// in the cycle an item is accepted, and its result is shown in the output
// register on the next cycle. The input is stalled only while a result is
// held in that register and the output side stalls it. Configuration writes
// are always ready and should only be issued while no command is in progress.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic       scl_level_i,
  input  logic       sda_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_release_o,
  output logic       sda_release_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic [1:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] half_period_q, ack_wait_q;
  logic [3:0] rec_rounds_q;

  phase_e     phase_q, phase_d;
  logic [7:0] hold_q, hold_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] pulse_q, pulse_d;
  logic [3:0] round_q, round_d;
  logic [7:0] ack_cnt_q, ack_cnt_d;
  logic       send_ack_q, send_ack_d;
  logic       scl_drv_q, scl_drv_d;
  logic       sda_drv_q, sda_drv_d;
  logic [1:0] status_q, status_d;
  logic [7:0] rx_q, rx_d;
  logic       done_q, done_d;
  logic       out_valid_q;

  logic       accept;
  logic [7:0] hold_lim, ack_lim, hold_inc, ack_inc;
  logic [3:0] rounds_lim, pulse_inc, round_inc, bit_inc;
  logic       held;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign hold_lim   = (half_period_q == 8'd0) ? 8'd1 : half_period_q;
  assign ack_lim    = (ack_wait_q == 8'd0) ? 8'd1 : ack_wait_q;
  assign rounds_lim = (rec_rounds_q == 4'd0) ? 4'd1 : rec_rounds_q;
  assign hold_inc   = (hold_q == 8'hFF) ? hold_q : hold_q + 8'd1;
  assign ack_inc    = (ack_cnt_q == 8'hFF) ? ack_cnt_q : ack_cnt_q + 8'd1;
  assign held       = (hold_inc >= hold_lim);
  assign pulse_inc  = pulse_q + 4'd1;
  assign round_inc  = round_q + 4'd1;
  assign bit_inc    = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    hold_d     = hold_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    pulse_d    = pulse_q;
    round_d    = round_q;
    ack_cnt_d  = ack_cnt_q;
    send_ack_d = send_ack_q;
    scl_drv_d  = scl_drv_q;
    sda_drv_d  = sda_drv_q;
    status_d   = status_q;
    rx_d       = rx_q;
    done_d     = 1'b0;

    if (phase_q == P_IDLE) begin
      case (command_i)
        CMD_START: begin
          shift_d   = data_byte_i;
          round_d   = 4'd0;
          pulse_d   = 4'd0;
          scl_drv_d = 1'b1;
          sda_drv_d = 1'b1;
          phase_d   = P_CHK;
          hold_d    = 8'd0;
        end
        CMD_WRITE: begin
          shift_d   = data_byte_i;
          bit_cnt_d = 4'd0;
          scl_drv_d = 1'b0;
          sda_drv_d = data_byte_i[7];
          phase_d   = P_WR_LO;
          hold_d    = 8'd0;
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          send_ack_d = (command_i == CMD_READ_ACK);
          shift_d    = 8'd0;
          bit_cnt_d  = 4'd0;
          scl_drv_d  = 1'b0;
          sda_drv_d  = 1'b1;
          phase_d    = P_RD_LO;
          hold_d     = 8'd0;
        end
        CMD_STOP: begin
          status_d  = ST_OK;
          scl_drv_d = 1'b0;
          sda_drv_d = 1'b0;
          phase_d   = P_SP_A;
          hold_d    = 8'd0;
        end
        default: begin
        end
      endcase
    end else begin
      if (phase_q != P_ACK_POLL) begin
        hold_d = held ? 8'd0 : hold_inc;
      end
      case (phase_q)
        P_CHK: begin
          if (held) begin
            if (scl_level_i && sda_level_i) begin
              phase_d = P_ST_A;
            end else begin
              pulse_d   = 4'd0;
              scl_drv_d = 1'b0;
              sda_drv_d = 1'b1;
              phase_d   = P_REC_LO;
            end
          end
        end
        P_REC_LO: begin
          if (held) begin
            scl_drv_d = 1'b1;
            sda_drv_d = 1'b1;
            phase_d   = P_REC_HI;
          end
        end
        P_REC_HI: begin
          if (held) begin
            if (pulse_inc < RECOVERY_PULSES) begin
              pulse_d   = pulse_inc;
              scl_drv_d = 1'b0;
              sda_drv_d = 1'b1;
              phase_d   = P_REC_LO;
            end else begin
              pulse_d = 4'd0;
              round_d = round_inc;
              if (round_inc >= rounds_lim) begin
                status_d = ST_STUCK;
                done_d   = 1'b1;
                phase_d  = P_IDLE;
              end else begin
                phase_d = P_CHK;
              end
            end
          end
        end
        P_ST_A: begin
          if (held) begin
            scl_drv_d = 1'b1;
            sda_drv_d = 1'b0;
            phase_d   = P_ST_B;
          end
        end
        P_ST_B: begin
          if (held) begin
            scl_drv_d = 1'b0;
            sda_drv_d = 1'b0;
            phase_d   = P_ST_C;
          end
        end
        P_ST_C: begin
          if (held) begin
            bit_cnt_d = 4'd0;
            scl_drv_d = 1'b0;
            sda_drv_d = shift_q[7];
            phase_d   = P_WR_LO;
          end
        end
        P_WR_LO: begin
          if (held) begin
            scl_drv_d = 1'b1;
            phase_d   = P_WR_HI;
          end
        end
        P_WR_HI: begin
          if (held) begin
            scl_drv_d = 1'b0;
            phase_d   = P_WR_END;
          end
        end
        P_WR_END: begin
          if (held) begin
            bit_cnt_d = bit_inc;
            shift_d   = {shift_q[6:0], 1'b0};
            scl_drv_d = 1'b0;
            if (bit_inc < BITS_PER_BYTE) begin
              sda_drv_d = shift_q[6];
              phase_d   = P_WR_LO;
            end else begin
              sda_drv_d = 1'b1;
              phase_d   = P_ACK_SET;
            end
          end
        end
        P_ACK_SET: begin
          if (held) begin
            scl_drv_d = 1'b1;
            sda_drv_d = 1'b1;
            ack_cnt_d = 8'd0;
            phase_d   = P_ACK_POLL;
          end
        end
        P_ACK_POLL: begin
          if (!sda_level_i) begin
            scl_drv_d = 1'b0;
            sda_drv_d = 1'b1;
            status_d  = ST_OK;
            done_d    = 1'b1;
            phase_d   = P_IDLE;
            hold_d    = 8'd0;
          end else begin
            ack_cnt_d = ack_inc;
            if (ack_inc >= ack_lim) begin
              status_d  = ST_NO_ACK;
              scl_drv_d = 1'b0;
              sda_drv_d = 1'b0;
              phase_d   = P_SP_A;
              hold_d    = 8'd0;
            end
          end
        end
        P_RD_LO: begin
          if (held) begin
            scl_drv_d = 1'b1;
            sda_drv_d = 1'b1;
            phase_d   = P_RD_HI;
          end
        end
        P_RD_HI: begin
          if (held) begin
            shift_d   = {shift_q[6:0], sda_level_i};
            bit_cnt_d = bit_inc;
            scl_drv_d = 1'b0;
            if (bit_inc < BITS_PER_BYTE) begin
              sda_drv_d = 1'b1;
              phase_d   = P_RD_LO;
            end else begin
              sda_drv_d = ~send_ack_q;
              phase_d   = P_RA_LO;
            end
          end
        end
        P_RA_LO: begin
          if (held) begin
            scl_drv_d = 1'b1;
            phase_d   = P_RA_HI;
          end
        end
        P_RA_HI: begin
          if (held) begin
            scl_drv_d = 1'b0;
            phase_d   = P_RA_END;
          end
        end
        P_RA_END: begin
          if (held) begin
            scl_drv_d = 1'b0;
            sda_drv_d = 1'b1;
            rx_d      = shift_q;
            status_d  = ST_OK;
            done_d    = 1'b1;
            phase_d   = P_IDLE;
          end
        end
        P_SP_A: begin
          if (held) begin
            scl_drv_d = 1'b1;
            sda_drv_d = 1'b0;
            phase_d   = P_SP_B;
          end
        end
        P_SP_B: begin
          if (held) begin
            scl_drv_d = 1'b1;
            sda_drv_d = 1'b1;
            phase_d   = P_SP_C;
          end
        end
        P_SP_C: begin
          if (held) begin
            done_d  = 1'b1;
            phase_d = P_IDLE;
          end
        end
        default: begin
          phase_d = P_IDLE;
          hold_d  = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
      ack_wait_q    <= ACK_WAIT_RESET;
      rec_rounds_q  <= RECOVERY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i;
        CFG_ACK_WAIT:    ack_wait_q    <= cfg_data_i;
        CFG_RECOVERY:    rec_rounds_q  <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= P_IDLE;
      hold_q     <= 8'd0;
      bit_cnt_q  <= 4'd0;
      shift_q    <= 8'd0;
      pulse_q    <= 4'd0;
      round_q    <= 4'd0;
      ack_cnt_q  <= 8'd0;
      send_ack_q <= 1'b0;
      scl_drv_q  <= 1'b1;
      sda_drv_q  <= 1'b1;
      status_q   <= ST_OK;
      rx_q       <= 8'd0;
      done_q     <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      hold_q     <= hold_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      pulse_q    <= pulse_d;
      round_q    <= round_d;
      ack_cnt_q  <= ack_cnt_d;
      send_ack_q <= send_ack_d;
      scl_drv_q  <= scl_drv_d;
      sda_drv_q  <= sda_drv_d;
      status_q   <= status_d;
      rx_q       <= rx_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_release_o = scl_drv_q;
  assign sda_release_o = sda_drv_q;
  assign busy_res_o    = (phase_q != P_IDLE);
  assign done_res_o    = done_q;
  assign rx_byte_o     = rx_q;
  assign status_o      = status_q;

endmodule
